// ----- hdl/glbdf_pkg.sv -----
// Shared constants, codes and types for the GLB container deframer.
package glbdf_pkg;

  // Container format constants (little-endian words)
  localparam logic [31:0] FILE_MAGIC   = 32'h4654_6C67;
  localparam logic [31:0] GLB_VERSION  = 32'h0000_0002;
  localparam logic [31:0] JSON_TYPE    = 32'h4E4F_534A;
  localparam logic [31:0] BIN_TYPE     = 32'h004E_4942;
  localparam logic [31:0] HEADER_BYTES = 32'd12;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  // Payload kind codes
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_JSON  = 2'd1;
  localparam logic [1:0] KIND_BIN   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_VERSION   = 3'd3;
  localparam logic [2:0] ST_LENGTH    = 3'd4;
  localparam logic [2:0] ST_OVERRUN   = 3'd5;
  localparam logic [2:0] ST_NO_JSON   = 3'd6;

  // One result word
  typedef struct packed {
    logic [1:0]  payload_kind;
    logic [7:0]  byte_out;
    logic [31:0] chunk_offset;
    logic [2:0]  status;
    logic        verdict_valid;
  } glbdf_result_t;

endpackage

// ----- hdl/glbdf_core.sv -----
// Per-byte parser state and next-state logic for the GLB deframer.
module glbdf_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,       // a byte is taken this cycle
  input  logic [7:0]             data_byte,
  input  logic                   end_of_file,
  output glbdf_pkg::glbdf_result_t res
);

  // Phase codes
  localparam logic [1:0] PH_HEADER    = 2'd0;
  localparam logic [1:0] PH_CHUNK_HDR = 2'd1;
  localparam logic [1:0] PH_PAYLOAD   = 2'd2;
  localparam logic [1:0] PH_IGNORE    = 2'd3;

  logic [31:0] byte_count_r, byte_count_nxt;
  logic [31:0] word_shift_r, word_shift_nxt;
  logic [31:0] decl_len_r, decl_len_nxt;
  logic [31:0] chunk_rem_r, chunk_rem_nxt;
  logic [31:0] payload_pos_r, payload_pos_nxt;
  logic [1:0]  chunk_kind_r, chunk_kind_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  pend_err_r, pend_err_nxt;
  logic        json_ok_r, json_ok_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;

  logic [31:0] shift_in;
  logic [3:0]  hdr_inc;
  logic [1:0]  new_kind;
  logic        no_room;
  logic        overrun;
  logic [1:0]  kind;
  logic [31:0] offset;
  logic [2:0]  verdict;

  assign shift_in = {data_byte, word_shift_r[31:8]};
  assign hdr_inc  = {1'b0, hdr_idx_r} + 4'd1;
  assign new_kind = (shift_in == glbdf_pkg::JSON_TYPE) ? glbdf_pkg::KIND_JSON :
                    (shift_in == glbdf_pkg::BIN_TYPE)  ? glbdf_pkg::KIND_BIN  :
                                                         glbdf_pkg::KIND_OTHER;
  // chunk header must fit within the declared length
  assign no_room  = ({1'b0, byte_count_r} + 33'd8) > {1'b0, decl_len_r};
  // chunk payload must end at or below the declared length
  assign overrun  = ({2'b0, byte_count_r} + 34'd1 + {2'b0, chunk_rem_r})
                    > {2'b0, decl_len_r};

  // Next-state logic for one byte
  always_comb begin
    word_shift_nxt  = word_shift_r;
    decl_len_nxt    = decl_len_r;
    chunk_rem_nxt   = chunk_rem_r;
    payload_pos_nxt = payload_pos_r;
    chunk_kind_nxt  = chunk_kind_r;
    phase_nxt       = phase_r;
    pend_err_nxt    = pend_err_r;
    json_ok_nxt     = json_ok_r;
    hdr_idx_nxt     = hdr_idx_r;
    kind            = glbdf_pkg::KIND_NONE;
    offset          = 32'd0;
    unique case (phase_r)
      PH_HEADER: begin
        word_shift_nxt = shift_in;
        if (byte_count_r == 32'd3 && shift_in != glbdf_pkg::FILE_MAGIC) begin
          pend_err_nxt = glbdf_pkg::ST_MAGIC;
        end
        if (byte_count_r == 32'd7 && pend_err_r == glbdf_pkg::ST_OK &&
            shift_in != glbdf_pkg::GLB_VERSION) begin
          pend_err_nxt = glbdf_pkg::ST_VERSION;
        end
        if (byte_count_r == glbdf_pkg::HEADER_BYTES - 32'd1) begin
          decl_len_nxt = shift_in;
          hdr_idx_nxt  = 3'd0;
          phase_nxt    = (pend_err_nxt != glbdf_pkg::ST_OK) ? PH_IGNORE : PH_CHUNK_HDR;
        end
      end
      PH_CHUNK_HDR: begin
        if (hdr_idx_r == 3'd0 && no_room) begin
          phase_nxt = PH_IGNORE;
        end else begin
          word_shift_nxt = shift_in;
          hdr_idx_nxt    = hdr_inc[2:0];   // wraps to zero after the eighth byte
          if (hdr_inc == 4'd4) begin
            chunk_rem_nxt = shift_in;
          end
          if (hdr_inc == 4'd8) begin
            if (overrun) begin
              pend_err_nxt = glbdf_pkg::ST_OVERRUN;
              phase_nxt    = PH_IGNORE;
            end else begin
              chunk_kind_nxt = new_kind;
              if (new_kind == glbdf_pkg::KIND_JSON) begin
                json_ok_nxt = (chunk_rem_r != 32'd0);
              end
              payload_pos_nxt = 32'd0;
              phase_nxt = (chunk_rem_r != 32'd0) ? PH_PAYLOAD : PH_CHUNK_HDR;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        kind            = chunk_kind_r;
        offset          = payload_pos_r;
        payload_pos_nxt = payload_pos_r + 32'd1;
        chunk_rem_nxt   = chunk_rem_r - 32'd1;
        if (chunk_rem_r == 32'd1) begin
          phase_nxt = PH_CHUNK_HDR;
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase
  end

  // Saturating byte counter
  assign byte_count_nxt = (byte_count_r == glbdf_pkg::COUNT_MAX) ? byte_count_r
                                                                 : byte_count_r + 32'd1;

  // Verdict, checked in priority order
  always_comb begin
    priority if (byte_count_nxt < glbdf_pkg::HEADER_BYTES) begin
      verdict = glbdf_pkg::ST_TOO_SMALL;
    end else if (pend_err_nxt == glbdf_pkg::ST_MAGIC ||
                 pend_err_nxt == glbdf_pkg::ST_VERSION) begin
      verdict = pend_err_nxt;
    end else if (decl_len_nxt > byte_count_nxt) begin
      verdict = glbdf_pkg::ST_LENGTH;
    end else if (pend_err_nxt == glbdf_pkg::ST_OVERRUN) begin
      verdict = glbdf_pkg::ST_OVERRUN;
    end else if (!json_ok_nxt) begin
      verdict = glbdf_pkg::ST_NO_JSON;
    end else begin
      verdict = glbdf_pkg::ST_OK;
    end
  end

  // Result word for this byte
  always_comb begin
    res.payload_kind  = kind;
    res.byte_out      = data_byte;
    res.chunk_offset  = offset;
    res.status        = end_of_file ? verdict : glbdf_pkg::ST_OK;
    res.verdict_valid = end_of_file;
  end

  // State registers; the final byte returns the parser to its reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_file)) begin
      byte_count_r  <= 32'd0;
      word_shift_r  <= 32'd0;
      decl_len_r    <= 32'd0;
      chunk_rem_r   <= 32'd0;
      payload_pos_r <= 32'd0;
      chunk_kind_r  <= glbdf_pkg::KIND_NONE;
      phase_r       <= PH_HEADER;
      pend_err_r    <= glbdf_pkg::ST_OK;
      json_ok_r     <= 1'b0;
      hdr_idx_r     <= 3'd0;
    end else if (step) begin
      byte_count_r  <= byte_count_nxt;
      word_shift_r  <= word_shift_nxt;
      decl_len_r    <= decl_len_nxt;
      chunk_rem_r   <= chunk_rem_nxt;
      payload_pos_r <= payload_pos_nxt;
      chunk_kind_r  <= chunk_kind_nxt;
      phase_r       <= phase_nxt;
      pend_err_r    <= pend_err_nxt;
      json_ok_r     <= json_ok_nxt;
      hdr_idx_r     <= hdr_idx_nxt;
    end
  end

  // Payload phase always has bytes left
  a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> chunk_rem_r != 32'd0)
    else $error("payload phase with no bytes left");

  // Chunk header byte index only advances inside a chunk header
  a_hdr_idx_phase: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r != 3'd0 |-> phase_r == PH_CHUNK_HDR)
    else $error("chunk header index outside chunk header phase");

  // File header phase never outlives the twelve header bytes
  a_header_short: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> byte_count_r < glbdf_pkg::HEADER_BYTES)
    else $error("file header phase past byte twelve");

endmodule

// ----- hdl/glb_container_deframer.sv -----
// Top level of the GLB container deframer: stream ports and result register.
// The result word for an accepted input byte is registered and appears in the next cycle.
// Throughput: one byte per cycle while the output is not stalled; the parser state updates once per accepted byte.
// A new byte is taken only when the result register is empty or its word leaves that cycle.
// Reset (rst_n low, synchronous) empties the result register and returns the parser
// to the file header; the parser also returns there after each end-of-file byte.
module glb_container_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] byte_out, [39:8] chunk_offset, [42:40] status, zero pad
  output logic [1:0]  out_tuser,  // [1:0] payload_kind
  output logic        out_tlast   // verdict_valid
);

  logic                     step;
  logic                     out_valid_r;
  glbdf_pkg::glbdf_result_t res;
  glbdf_pkg::glbdf_result_t res_r;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  glbdf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_tdata),
    .end_of_file (in_tlast),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.status, res_r.chunk_offset, res_r.byte_out};
  assign out_tuser  = res_r.payload_kind;
  assign out_tlast  = res_r.verdict_valid;

  // A nonzero status only appears on the final word of a file
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status != glbdf_pkg::ST_OK |-> res_r.verdict_valid)
    else $error("status reported before end of file");

  // A result that was not taken stays in the register
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(res_r))
    else $error("pending result lost");

  // Status never carries an undefined code
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.status != 3'd7)
    else $error("undefined status code");

endmodule
